// ===== rtl/core/cfp_pkg.sv =====
// cfp_pkg: types, constants and helper functions of the coordinate frame parser
// used by cfp_step and coordinate_frame_parser; no dependencies
`timescale 1ns / 1ps

package cfp_pkg;

    localparam int LINE_LIMIT = 64;
    localparam int LINE_W     = $clog2(LINE_LIMIT);
    localparam int TICK_W     = 26;

    localparam logic [TICK_W-1:0] TIMEOUT_RESET = TICK_W'(3000000);
    localparam logic [TICK_W-1:0] IDLE_MAX      = {TICK_W{1'b1}};

    localparam logic [7:0] CH_HEAD  = 8'h42;   // 'B'
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_TAB   = 8'h09;

    localparam logic [0:0] ACT_BYTE = 1'b0;
    localparam logic [0:0] ACT_TICK = 1'b1;

    typedef enum logic [3:0] {
        PH_HEAD, PH_COMMA, PH_XWS, PH_XSIGN, PH_XDIG,
        PH_YWS, PH_YSIGN, PH_YDIG, PH_TAIL, PH_BAD, PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        ST_NONE, ST_VALID, ST_MALFORMED, ST_OVERLONG
    } t_status;

    typedef struct packed {
        logic [0:0] action;
        logic [7:0] rx_byte;
    } t_in;

    typedef struct packed {
        t_status            frame_status;
        logic signed [31:0] x_coord;
        logic signed [31:0] y_coord;
        logic               led_on;
    } t_out;

    typedef struct packed {
        t_phase              parse_phase;
        logic [LINE_W-1:0]   line_count;
        logic [31:0]         x_magnitude;
        logic [31:0]         y_magnitude;
        logic                x_negative;
        logic                y_negative;
        logic                link_led;
        logic                ever_valid;
        logic [TICK_W-1:0]   idle_count;
    } t_state;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // mag * 10 + digit, saturating at 32 bits
    function automatic logic [31:0] accum(input logic [31:0] mag, input logic [7:0] c);
        logic [35:0] v;
        v = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0} + {32'd0, c[3:0]};
        return (v[35:32] != 4'd0) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic logic [31:0] finish(input logic [31:0] mag, input logic neg);
        logic [31:0] m;
        if (neg) begin
            m = (mag > 32'h8000_0000) ? 32'h8000_0000 : mag;
            return 32'd0 - m;
        end
        return (mag > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag;
    endfunction

endpackage

// ===== rtl/core/cfp_step.sv =====
// cfp_step: combinational next-state and result logic for one beat
// depends on cfp_pkg
`timescale 1ns / 1ps

module cfp_step
    import cfp_pkg::*;
(
    input  t_state              i_state,
    input  t_in                 i_item,
    input  logic [TICK_W-1:0]   i_timeout,
    output t_state              o_state,
    output t_out                o_result
);

    logic [7:0]        c;
    logic [TICK_W-1:0] idle_inc;
    logic [31:0]       xv;
    logic [31:0]       yv;

    assign c  = i_item.rx_byte;
    assign xv = finish(i_state.x_magnitude, i_state.x_negative);
    assign yv = finish(i_state.y_magnitude, i_state.y_negative);
    assign idle_inc = (i_state.idle_count < IDLE_MAX) ?
                      i_state.idle_count + TICK_W'(1) : i_state.idle_count;

    always_comb begin
        o_state               = i_state;
        o_result.frame_status = ST_NONE;
        o_result.x_coord      = '0;
        o_result.y_coord      = '0;

        if (i_item.action == ACT_TICK) begin
            if (i_state.ever_valid) begin
                o_state.idle_count = idle_inc;
                if (idle_inc > i_timeout) begin
                    o_state.link_led = 1'b0;
                end
            end
        end else if (c == CH_LF) begin
            if (i_state.line_count != '0) begin
                if (i_state.parse_phase == PH_YDIG || i_state.parse_phase == PH_TAIL ||
                    i_state.parse_phase == PH_DONE) begin
                    o_result.frame_status = ST_VALID;
                    o_result.x_coord      = xv;
                    o_result.y_coord      = yv;
                    o_state.ever_valid    = 1'b1;
                    o_state.idle_count    = '0;
                    o_state.link_led      = ~xv[31];
                end else begin
                    o_result.frame_status = ST_MALFORMED;
                end
            end
            o_state.parse_phase = PH_HEAD;
            o_state.line_count  = '0;
            o_state.x_magnitude = '0;
            o_state.y_magnitude = '0;
            o_state.x_negative  = 1'b0;
            o_state.y_negative  = 1'b0;
        end else if (i_state.line_count < LINE_W'(LINE_LIMIT - 1)) begin
            o_state.line_count = i_state.line_count + LINE_W'(1);
            unique case (i_state.parse_phase)
                PH_HEAD: begin
                    o_state.parse_phase = (c == CH_HEAD) ? PH_COMMA : PH_BAD;
                end
                PH_COMMA: begin
                    o_state.parse_phase = (c == CH_COMMA) ? PH_XWS : PH_BAD;
                end
                PH_XWS: begin
                    if (is_ws(c)) begin
                        o_state.parse_phase = PH_XWS;
                    end else if (c == CH_PLUS || c == CH_MINUS) begin
                        o_state.x_negative  = (c == CH_MINUS);
                        o_state.parse_phase = PH_XSIGN;
                    end else if (is_digit(c)) begin
                        o_state.x_magnitude = accum(i_state.x_magnitude, c);
                        o_state.parse_phase = PH_XDIG;
                    end else begin
                        o_state.parse_phase = PH_BAD;
                    end
                end
                PH_XSIGN, PH_XDIG: begin
                    if (is_digit(c)) begin
                        o_state.x_magnitude = accum(i_state.x_magnitude, c);
                        o_state.parse_phase = PH_XDIG;
                    end else if (i_state.parse_phase == PH_XDIG && c == CH_COMMA) begin
                        o_state.parse_phase = PH_YWS;
                    end else begin
                        o_state.parse_phase = PH_BAD;
                    end
                end
                PH_YWS: begin
                    if (is_ws(c)) begin
                        o_state.parse_phase = PH_YWS;
                    end else if (c == CH_PLUS || c == CH_MINUS) begin
                        o_state.y_negative  = (c == CH_MINUS);
                        o_state.parse_phase = PH_YSIGN;
                    end else if (is_digit(c)) begin
                        o_state.y_magnitude = accum(i_state.y_magnitude, c);
                        o_state.parse_phase = PH_YDIG;
                    end else begin
                        o_state.parse_phase = PH_BAD;
                    end
                end
                PH_YSIGN: begin
                    if (is_digit(c)) begin
                        o_state.y_magnitude = accum(i_state.y_magnitude, c);
                        o_state.parse_phase = PH_YDIG;
                    end else begin
                        o_state.parse_phase = PH_BAD;
                    end
                end
                PH_YDIG, PH_TAIL: begin
                    if (i_state.parse_phase == PH_YDIG && is_digit(c)) begin
                        o_state.y_magnitude = accum(i_state.y_magnitude, c);
                    end else if (c == CH_SPACE || c == CH_CR) begin
                        o_state.parse_phase = PH_TAIL;
                    end else if (c == CH_NUL) begin
                        o_state.parse_phase = PH_DONE;
                    end else begin
                        o_state.parse_phase = PH_BAD;
                    end
                end
                PH_DONE: begin
                    o_state.parse_phase = PH_DONE;
                end
                default: begin
                    o_state.parse_phase = PH_BAD;
                end
            endcase
        end else begin
            // line full: drop the byte and restart
            o_result.frame_status = ST_OVERLONG;
            o_state.parse_phase   = PH_HEAD;
            o_state.line_count    = '0;
            o_state.x_magnitude   = '0;
            o_state.y_magnitude   = '0;
            o_state.x_negative    = 1'b0;
            o_state.y_negative    = 1'b0;
        end

        o_result.led_on = o_state.link_led;
    end

endmodule

// ===== rtl/core/coordinate_frame_parser.sv =====
// coordinate_frame_parser: top level with parse state, timeout register and output skid
// depends on cfp_pkg and cfp_step
`timescale 1ns / 1ps

// Usage
//   input channel : i_in_valid / o_in_stall / i_in_data; each beat is either a
//                   received byte (action 0) or one microsecond tick (action 1)
//   output channel: o_out_valid / i_out_stall / o_out_data; exactly one result
//                   beat per input beat, in order
//   config        : i_cfg_we / i_cfg_wdata write timeout_ticks; write only while idle
// Each result is registered in the output register, or in the skid while the
// receiver stalls. Throughput is one beat per cycle while o_in_stall is low;
// the parse step for a byte is a single pass through cfp_step between the state
// registers and the output register. A two-entry output (output register plus
// skid) lets one more beat in while the receiver stalls; o_in_stall rises only
// when both are full. Reset clears the line parser, turns the LED off, clears the
// idle counter and loads timeout_ticks with 3000000; no result is pending after reset.

module coordinate_frame_parser
    import cfp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in               i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out              o_out_data,
    input  logic              i_cfg_we,
    input  logic [TICK_W-1:0] i_cfg_wdata
);

    t_state            r_state;
    t_state            n_state;
    t_out              n_result;
    logic [TICK_W-1:0] r_timeout;
    t_out              r_out;
    logic              r_out_valid;
    t_out              r_skid;
    logic              r_skid_valid;
    logic              in_accept;
    logic              out_pop;

    assign o_in_stall  = r_skid_valid;
    assign in_accept   = i_in_valid && !r_skid_valid;
    assign out_pop     = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    cfp_step u_step (
        .i_state  (r_state),
        .i_item   (i_in_data),
        .i_timeout(r_timeout),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= '0;
            r_timeout <= TIMEOUT_RESET;
        end else begin
            if (in_accept) begin
                r_state <= n_state;
            end
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_pop) begin
            if (r_skid_valid) begin
                r_out_valid <= 1'b1;
                r_out       <= r_skid;
                // skid is full, so no beat is taken this cycle
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_accept;
                if (in_accept) begin
                    r_out <= n_result;
                end
            end
        end else if (in_accept) begin
            r_skid_valid <= 1'b1;
            r_skid       <= n_result;
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a beat while output register is empty");

    a_led_needs_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.ever_valid |-> !r_state.link_led)
        else $error("led lit before any valid frame");

    a_coords_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_status != ST_VALID) |->
            (r_out.x_coord == 32'sd0 && r_out.y_coord == 32'sd0))
        else $error("nonzero coordinates on a non-frame result");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_out_stall) |=> !r_skid_valid)
        else $error("skid not drained after output pop");

endmodule
